// ===== rtl/fbfl_pkg.sv =====
// fbfl_pkg: widths, codes and FSM type for the fixed-block free-list allocator.
// No dependencies; used by the interfaces and the top level.
`timescale 1ns / 1ps

package fbfl_pkg;

  // field widths
  localparam int IDX_W      = 11;
  localparam int STRIDE_W   = 16;
  localparam int HDR_W      = 8;
  localparam int OFF_W      = 26;
  localparam int OP_W       = 2;
  localparam int ST_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_STRIDE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES = 2'd2;

  // register values after reset
  localparam logic [IDX_W-1:0]    RST_BLOCK_COUNT  = 11'd1024;
  localparam logic [STRIDE_W-1:0] RST_BLOCK_STRIDE = 16'd272;
  localparam logic [HDR_W-1:0]    RST_HEADER_BYTES = 8'd16;

  // use count saturates here
  localparam logic [IDX_W-1:0] CNT_MAX = '1;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_POP
  } fbfl_state_t;

endpackage

// ===== rtl/fbfl_req_if.sv =====
// fbfl_req_if: request channel (op, free_index) with valid/ready handshake.
// Depends on fbfl_pkg.
`timescale 1ns / 1ps

interface fbfl_req_if
  import fbfl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  op;
  logic [IDX_W-1:0] free_index;

  modport source (output valid, op, free_index, input ready);
  modport sink   (input valid, op, free_index, output ready);
endinterface

// ===== rtl/fbfl_rsp_if.sv =====
// fbfl_rsp_if: response channel (status, index, offset, use count) with valid/ready.
// Depends on fbfl_pkg.
`timescale 1ns / 1ps

interface fbfl_rsp_if
  import fbfl_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [ST_W-1:0]  status;
  logic [IDX_W-1:0] block_index;
  logic [OFF_W-1:0] data_offset;
  logic [IDX_W-1:0] used_count;

  modport source (output valid, status, block_index, data_offset, used_count, input ready);
  modport sink   (input valid, status, block_index, data_offset, used_count, output ready);
endinterface

// ===== rtl/fbfl_ram.sv =====
// fbfl_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module fbfl_ram #(
  parameter int WIDTH = 11,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read, held when not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fixed_block_free_list_allocator_unit.sv =====
// fixed_block_free_list_allocator_unit: top level of the block pool allocator.
// Depends on fbfl_pkg, fbfl_req_if, fbfl_rsp_if and fbfl_ram.
`timescale 1ns / 1ps

// Pool of equal-size blocks numbered 1..N (N = min(block_count, MAX_BLOCKS)),
// 0 meaning none, kept on a singly linked free list in one RAM.
// req carries op (init, alloc, free, nop) and free_index; rsp returns one beat
// per request: status, block_index, payload byte offset and the use count.
// cfg_wr_en/cfg_index/cfg_wdata write block_count, block_stride, header_bytes;
// write them only while no request is in flight.
// Steps per request, paced by the link RAM's registered read:
//   free, nop, bad free, empty alloc: done on accept, one request per cycle while rsp keeps up.
//   alloc: read of the head's link, then head update.
//   init: the accept, then one link written per cycle (done on accept when N is 0).
// A completed request's response is registered, not combinational. A result stage
// and the output register sit between the sides, so one request is taken
// while a response waits; after that req.ready drops until rsp drains.
// Reset (rst, synchronous) empties the list, clears the use count and
// loads default configuration; the link RAM is not cleared, init writes it.
module fixed_block_free_list_allocator_unit
  import fbfl_pkg::*;
#(
  parameter int MAX_BLOCKS = 1024
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  fbfl_req_if.sink              req,
  fbfl_rsp_if.source            rsp
);

  localparam int AW = $clog2(MAX_BLOCKS);

  // configuration
  logic [IDX_W-1:0]    block_count;
  logic [STRIDE_W-1:0] block_stride;
  logic [HDR_W-1:0]    header_bytes;

  // list state
  fbfl_state_t      state, state_next;
  logic [IDX_W-1:0] free_head, free_head_next;
  logic [IDX_W-1:0] use_count, use_count_next;
  logic [IDX_W-1:0] walk_idx, walk_idx_next;

  // RAM port signals
  logic             ram_we, ram_re;
  logic [AW-1:0]    ram_waddr, ram_raddr;
  logic [IDX_W-1:0] ram_wdata, ram_rdata;

  // result stage and output register
  logic             res_valid, res_load;
  status_t          res_status, res_status_next;
  logic [IDX_W-1:0] res_blk, res_blk_next;
  logic [OFF_W-1:0] res_off, res_off_next;
  logic [IDX_W-1:0] res_used;
  logic             out_valid, out_free;
  logic [ST_W-1:0]  out_status;
  logic [IDX_W-1:0] out_blk, out_used;
  logic [OFF_W-1:0] out_off;

  // misc
  logic                      req_fire;
  op_t                       req_op;
  logic [IDX_W-1:0]          eff_n;
  logic                      head_ok, free_ok;
  logic [IDX_W-1:0]          off_idx;
  logic                      off_en;
  logic [IDX_W+STRIDE_W-1:0] off_prod, off_sum;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      block_count  <= RST_BLOCK_COUNT;
      block_stride <= RST_BLOCK_STRIDE;
      header_bytes <= RST_HEADER_BYTES;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_BLOCK_COUNT:  block_count  <= cfg_wdata[IDX_W-1:0];
        CFG_BLOCK_STRIDE: block_stride <= cfg_wdata[STRIDE_W-1:0];
        CFG_HEADER_BYTES: header_bytes <= cfg_wdata[HDR_W-1:0];
        default: ;
      endcase
    end
  end

  // effective pool size and range checks
  assign eff_n   = (32'(block_count) > MAX_BLOCKS) ? IDX_W'(MAX_BLOCKS) : block_count;
  assign head_ok = (free_head != '0) && (free_head <= eff_n);
  assign free_ok = (req.free_index != '0) && (req.free_index <= eff_n);

  // handshake
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && (!res_valid || out_free);
  assign req_fire  = req.valid && req.ready;
  assign req_op    = op_t'(req.op);

  // payload offset: (index-1)*stride + header
  assign off_prod = (IDX_W+STRIDE_W)'(off_idx - IDX_W'(1)) * (IDX_W+STRIDE_W)'(block_stride);
  assign off_sum  = off_prod + (IDX_W+STRIDE_W)'(header_bytes);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_fire && req_op == OP_INIT && eff_n != '0) begin
          state_next = S_WALK;
        end else if (req_fire && req_op == OP_ALLOC && head_ok) begin
          state_next = S_POP;
        end
      end
      S_WALK: begin
        if (walk_idx == eff_n) begin
          state_next = S_IDLE;
        end
      end
      S_POP:   state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath control and result build
  always_comb begin
    ram_we          = 1'b0;
    ram_waddr       = '0;
    ram_wdata       = '0;
    ram_re          = 1'b0;
    ram_raddr       = AW'(free_head - IDX_W'(1));
    res_load        = 1'b0;
    res_status_next = ST_OK;
    res_blk_next    = '0;
    off_en          = 1'b0;
    off_idx         = free_head;
    free_head_next  = free_head;
    use_count_next  = use_count;
    walk_idx_next   = walk_idx;
    unique case (state)
      S_IDLE: begin
        if (req_fire) begin
          unique case (req_op)
            OP_INIT: begin
              free_head_next = (eff_n != '0) ? IDX_W'(1) : '0;
              use_count_next = '0;
              walk_idx_next  = IDX_W'(1);
              res_load       = (eff_n == '0);
            end
            OP_ALLOC: begin
              if (head_ok) begin
                ram_re = 1'b1;
              end else begin
                res_load        = 1'b1;
                res_status_next = ST_EMPTY;
              end
            end
            OP_FREE: begin
              res_load = 1'b1;
              if (free_ok) begin
                ram_we         = 1'b1;
                ram_waddr      = AW'(req.free_index - IDX_W'(1));
                ram_wdata      = free_head;
                free_head_next = req.free_index;
                use_count_next = (use_count == '0) ? '0 : use_count - IDX_W'(1);
                res_blk_next   = req.free_index;
                off_idx        = req.free_index;
                off_en         = 1'b1;
              end else begin
                res_status_next = ST_RANGE;
              end
            end
            OP_NOP: res_load = 1'b1;
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // link block walk_idx to its successor, last one ends the list
        ram_we        = 1'b1;
        ram_waddr     = AW'(walk_idx - IDX_W'(1));
        ram_wdata     = (walk_idx < eff_n) ? walk_idx + IDX_W'(1) : '0;
        walk_idx_next = walk_idx + IDX_W'(1);
        res_load      = (walk_idx == eff_n);
      end
      S_POP: begin
        free_head_next = ram_rdata;
        use_count_next = (use_count == CNT_MAX) ? CNT_MAX : use_count + IDX_W'(1);
        res_load       = 1'b1;
        res_blk_next   = free_head;
        off_en         = 1'b1;
      end
      default: ;
    endcase
    res_off_next = off_en ? off_sum[OFF_W-1:0] : '0;
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      use_count <= '0;
      walk_idx  <= '0;
      res_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      free_head <= free_head_next;
      use_count <= use_count_next;
      walk_idx  <= walk_idx_next;
      res_valid <= res_load || (res_valid && !out_free);
      if (res_valid && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result stage payload
  always_ff @(posedge clk) begin
    if (res_load) begin
      res_status <= res_status_next;
      res_blk    <= res_blk_next;
      res_off    <= res_off_next;
      res_used   <= use_count_next;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (res_valid && out_free) begin
      out_status <= res_status;
      out_blk    <= res_blk;
      out_off    <= res_off;
      out_used   <= res_used;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.block_index = out_blk;
  assign rsp.data_offset = out_off;
  assign rsp.used_count  = out_used;

  // link memory
  fbfl_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // a waiting result holds until the output register takes it
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !out_free |=> res_valid && $stable(res_blk) && $stable(res_off))
    else $error("result stage lost or changed a waiting result");

  // the pop step returns to idle in the following cycle
  a_pop_once: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |=> state == S_IDLE)
    else $error("pop step did not return to idle");

  // the init walk only writes blocks inside the pool
  a_walk_range: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK |-> walk_idx != '0 && walk_idx <= eff_n)
    else $error("init walk left the pool range");

  // the use count moves only on an accepted request or a pop
  a_count_quiet: assert property (@(posedge clk) disable iff (rst)
    !req_fire && state != S_POP |=> $stable(use_count))
    else $error("use count changed without a request");

endmodule

// ===== tb/tb_fixed_block_free_list_allocator_unit.sv =====
// tb_fixed_block_free_list_allocator_unit: self-checking bench for the block pool allocator.
// Depends on fbfl_pkg, fbfl_req_if, fbfl_rsp_if and the allocator top level.
`timescale 1ns / 1ps

module tb_fixed_block_free_list_allocator_unit;
  import fbfl_pkg::*;

  localparam int MAX_BLOCKS   = 1024;
  localparam int RANDOM_ITEMS = 1160;
  localparam int CYCLE_LIMIT  = 400000;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] block_index;
    logic [OFF_W-1:0] data_offset;
    logic [IDX_W-1:0] used_count;
  } pool_rsp_t;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  fbfl_req_if req_ch ();
  fbfl_rsp_if rsp_ch ();

  fixed_block_free_list_allocator_unit #(
    .MAX_BLOCKS(MAX_BLOCKS)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .req      (req_ch),
    .rsp      (rsp_ch)
  );

  always #2 clk = ~clk;

  // pool shadow: link store, list head, use count and register copies
  logic [IDX_W-1:0]    link_mem [MAX_BLOCKS];
  logic [IDX_W-1:0]    pool_head;
  logic [IDX_W-1:0]    pool_used;
  logic [IDX_W-1:0]    cfg_count;
  logic [STRIDE_W-1:0] cfg_stride;
  logic [HDR_W-1:0]    cfg_hdr;

  pool_rsp_t        pending_rsp_q [$];
  logic [IDX_W-1:0] held_blocks_q [$];
  pool_rsp_t        oldest_rsp;

  int errors;
  int cycle_count;
  int burst_left;
  bit tx_gaps;
  int rx_mode;
  int rx_tick;
  int n_init, n_alloc, n_empty, n_free, n_bad_free, n_nop, n_beats;

  // effective pool size: block_count clamped to the pool depth
  function automatic logic [IDX_W-1:0] pool_size();
    return (cfg_count > MAX_BLOCKS) ? IDX_W'(MAX_BLOCKS) : cfg_count;
  endfunction

  function automatic logic [OFF_W-1:0] payload_offset(logic [IDX_W-1:0] blk);
    logic [42:0] offs;
    offs = 43'(blk) - 43'd1;
    offs = offs * 43'(cfg_stride) + 43'(cfg_hdr);
    return offs[OFF_W-1:0];
  endfunction

  // advance the shadow pool by one request and return its response
  function automatic pool_rsp_t pool_predict(op_t op, logic [IDX_W-1:0] fidx);
    pool_rsp_t        r;
    logic [IDX_W-1:0] n;
    int               i;
    n             = pool_size();
    r.status      = ST_OK;
    r.block_index = '0;
    r.data_offset = '0;
    case (op)
      OP_INIT: begin
        for (i = 1; i <= n; i++) link_mem[i-1] = (i < n) ? IDX_W'(i + 1) : '0;
        pool_head = (n > 0) ? IDX_W'(1) : '0;
        pool_used = '0;
        n_init++;
      end
      OP_ALLOC: begin
        if (pool_head == 0 || pool_head > n) begin
          r.status = ST_EMPTY;
          n_empty++;
        end else begin
          r.block_index = pool_head;
          r.data_offset = payload_offset(pool_head);
          pool_head     = link_mem[pool_head-1];
          if (pool_used != CNT_MAX) pool_used++;
          n_alloc++;
        end
      end
      OP_FREE: begin
        if (fidx == 0 || fidx > n) begin
          r.status = ST_RANGE;
          n_bad_free++;
        end else begin
          r.block_index    = fidx;
          r.data_offset    = payload_offset(fidx);
          link_mem[fidx-1] = pool_head;
          pool_head        = fidx;
          if (pool_used != 0) pool_used--;
          n_free++;
        end
      end
      default: n_nop++;
    endcase
    r.used_count = pool_used;
    return r;
  endfunction

  // one request beat: optional gap, drive at falling edge, hold until taken
  task automatic send_item(op_t op, logic [IDX_W-1:0] fidx);
    int        gap;
    pool_rsp_t r;
    if (burst_left == 0) begin
      gap = tx_gaps ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
        @(negedge clk);
        req_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk);
    req_ch.valid      <= 1'b1;
    req_ch.op         <= op;
    req_ch.free_index <= fidx;
    do @(posedge clk); while (!req_ch.ready);
    r = pool_predict(op, fidx);
    pending_rsp_q.push_back(r);
    if (op == OP_INIT) held_blocks_q.delete();
    if (op == OP_ALLOC && r.status == ST_OK) held_blocks_q.push_back(r.block_index);
  endtask

  // stop sending and let every outstanding response drain
  task automatic wait_idle();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_BLOCK_COUNT:  cfg_count  = val[IDX_W-1:0];
      CFG_BLOCK_STRIDE: cfg_stride = val[STRIDE_W-1:0];
      CFG_HEADER_BYTES: cfg_hdr    = val[HDR_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_pool(int count, int stride, int hdr);
    write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(count));
    write_reg(CFG_BLOCK_STRIDE, CFG_DATA_W'(stride));
    write_reg(CFG_HEADER_BYTES, CFG_DATA_W'(hdr));
  endtask

  // receive side: ready pattern chosen per phase
  always @(negedge clk) begin
    rx_tick++;
    case (rx_mode)
      0:       rsp_ch.ready <= 1'b1;
      1:       rsp_ch.ready <= ($urandom_range(0, 99) < 70);
      2:       rsp_ch.ready <= (rx_tick % 7) > 2;
      default: rsp_ch.ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // compare each response beat with the oldest prediction
  always @(posedge clk) begin
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      n_beats++;
      if (pending_rsp_q.size() == 0) begin
        errors++;
        $display("%0t ns: response beat with none expected, index %0d", $time,
                 rsp_ch.block_index);
      end else begin
        oldest_rsp = pending_rsp_q.pop_front();
        check_field("status", oldest_rsp.status, rsp_ch.status);
        check_field("block_index", oldest_rsp.block_index, rsp_ch.block_index);
        check_field("data_offset", oldest_rsp.data_offset, rsp_ch.data_offset);
        check_field("used_count", oldest_rsp.used_count, rsp_ch.used_count);
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout, %0d responses outstanding", $time, pending_rsp_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // right after reset: empty list, out-of-range frees, a free onto the empty list
  task automatic test_after_reset();
    rx_mode = 1;
    tx_gaps = 1'b1;
    send_item(OP_ALLOC, '0);
    send_item(OP_NOP, '1);
    send_item(OP_FREE, '0);
    send_item(OP_FREE, 11'd2047);
    send_item(OP_FREE, 11'd1);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
  endtask

  // small pool at widest stride and header: drain it, free a block back, bad indexes
  task automatic test_small_pool();
    rx_mode = 2;
    set_pool(3, 65535, 255);
    send_item(OP_INIT, 11'd1365);
    repeat (4) send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 11'd3);
    send_item(OP_FREE, 11'd0);
    send_item(OP_FREE, 11'd4);
    send_item(OP_ALLOC, 11'd682);
    send_item(OP_NOP, '0);
  endtask

  // full pool, largest offset, then the clamp of block_count above the depth
  task automatic test_offset_extremes();
    rx_mode = 0;
    set_pool(1024, 65535, 255);
    send_item(OP_INIT, '0);
    send_item(OP_FREE, 11'd1024);
    send_item(OP_ALLOC, '0);
    set_pool(2047, 1, 0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 11'd1024);
    send_item(OP_FREE, 11'd1025);
    send_item(OP_ALLOC, '0);
  endtask

  // head left above a lowered block_count reads as empty
  task automatic test_stale_head();
    rx_mode = 3;
    set_pool(8, 100, 7);
    send_item(OP_INIT, '0);
    repeat (4) send_item(OP_ALLOC, '0);
    write_reg(CFG_BLOCK_COUNT, 16'd4);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 11'd5);
    send_item(OP_FREE, 11'd2);
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '0);
  endtask

  // zero blocks: init leaves the list empty
  task automatic test_zero_count();
    rx_mode = 1;
    write_reg(CFG_BLOCK_COUNT, 16'd0);
    send_item(OP_INIT, '0);
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, 11'd1);
  endtask

  // a double free makes block 1 point at itself, so allocs never run dry
  // and the use count climbs past the pool size; frees then bring it down and hold it at zero
  task automatic test_self_loop();
    rx_mode = 0;
    tx_gaps = 1'b0;
    set_pool(1, 64, 0);
    send_item(OP_INIT, '0);
    send_item(OP_FREE, 11'd1);
    repeat (24) send_item(OP_ALLOC, '0);
    repeat (26) send_item(OP_FREE, 11'd1);
    tx_gaps = 1'b1;
  endtask

  function automatic int pick_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 16);
    if (r < 90) return $urandom_range(17, 128);
    if (r < 94) return 1024;
    if (r < 96) return 0;
    if (r < 98) return $urandom_range(1025, 2047);
    return 1;
  endfunction

  function automatic int pick_stride();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 1;
    if (r == 1) return 65535;
    return $urandom_range(1, 65535);
  endfunction

  function automatic int pick_header();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 0;
    if (r == 1) return 255;
    return $urandom_range(0, 255);
  endfunction

  // rounds of init followed by mostly well-formed alloc/free traffic
  task automatic test_random_traffic();
    int               sent;
    int               len;
    int               k;
    int               pick;
    int               slot;
    logic [IDX_W-1:0] fidx;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      rx_mode = $urandom_range(0, 3);
      tx_gaps = ($urandom_range(0, 3) != 0);
      write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(pick_count()));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_BLOCK_STRIDE, CFG_DATA_W'(pick_stride()));
      if ($urandom_range(0, 2) == 0) write_reg(CFG_HEADER_BYTES, CFG_DATA_W'(pick_header()));
      send_item(OP_INIT, IDX_W'($urandom_range(0, 2047)));
      sent++;
      len = $urandom_range(8, 60);
      for (k = 0; k < len; k++) begin
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          send_item(OP_ALLOC, IDX_W'($urandom_range(0, 2047)));
        end else if (pick < 80 && held_blocks_q.size() != 0) begin
          slot = $urandom_range(0, held_blocks_q.size() - 1);
          fidx = held_blocks_q[slot];
          held_blocks_q.delete(slot);
          send_item(OP_FREE, fidx);
        end else if (pick < 90) begin
          if ($urandom_range(0, 1) == 0)
            fidx = IDX_W'($urandom_range(0, int'(pool_size()) + 2));
          else
            fidx = IDX_W'($urandom_range(0, 2047));
          send_item(OP_FREE, fidx);
        end else if (pick < 95) begin
          send_item(OP_NOP, IDX_W'($urandom_range(0, 2047)));
        end else if (pick < 97) begin
          send_item(OP_INIT, IDX_W'($urandom_range(0, 2047)));
        end else if (pick < 99) begin
          // hold off until the block has answered everything
          wait_idle();
          continue;
        end else begin
          // shrink or grow the pool under a live list
          write_reg(CFG_BLOCK_COUNT, CFG_DATA_W'(pick_count()));
          continue;
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst               = 1'b1;
    cfg_wr_en         = 1'b0;
    cfg_index         = CFG_BLOCK_COUNT;
    cfg_wdata         = '0;
    req_ch.valid      = 1'b0;
    req_ch.op         = OP_NOP;
    req_ch.free_index = '0;
    cfg_count         = RST_BLOCK_COUNT;
    cfg_stride        = RST_BLOCK_STRIDE;
    cfg_hdr           = RST_HEADER_BYTES;
    pool_head         = '0;
    pool_used         = '0;
    rx_mode           = 0;
    burst_left        = 0;
    tx_gaps           = 1'b1;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_after_reset();
    test_small_pool();
    test_offset_extremes();
    test_stale_head();
    test_zero_count();
    test_self_loop();
    test_random_traffic();

    wait_idle();
    repeat (20) @(posedge clk);
    $display("Checked %0d response beats: %0d inits, %0d allocs, %0d empty pops, %0d frees,",
             n_beats, n_init, n_alloc, n_empty, n_free);
    $display("%0d rejected frees, %0d no-ops, over pool sizes 0 to 2047 and stride/header extremes",
             n_bad_free, n_nop);
    if (errors == 0 && pending_rsp_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
